>>> sv/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg: shared constants, types and functions
// Sizes, codes, the quarter-wave sine table and the shade bands
// used by the column raycaster.
// ----------------------------------------------------------------------------
`default_nettype none

package grc_pkg;

   localparam int GRID_SIDE       = 32;
   localparam int MAX_DEPTH_CELLS = 20;
   localparam int ANGLE_STEPS     = 4096;

   localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W     = $clog2(GRID_DEPTH);
   localparam int IDX_W      = $clog2(GRID_SIDE);
   localparam int ANGLE_W    = $clog2(ANGLE_STEPS);

   // field widths
   localparam int CELL_XY_W = 5;
   localparam int POS_W     = 13;
   localparam int COLUMN_W  = 10;
   localparam int ROW_W     = 9;
   localparam int SHADE_W   = 4;
   localparam int STEP_W    = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 11;

   localparam logic [STEP_W-1:0] MAX_STEPS = STEP_W'(MAX_DEPTH_CELLS * 10);
   localparam logic [STEP_W-1:0] NEAR_STEPS = STEP_W'(20);

   // march arithmetic: probe denominator 10 * 2^22
   localparam int CELL_W = 7;
   localparam int REM_W  = 26;
   localparam logic signed [REM_W:0] PROBE_DEN = 27'sd41943040;
   localparam logic [REM_W-1:0] FRAC_SCALE = 26'd163840;

   // divider
   localparam int DIV_W   = 21;
   localparam int DIVR_W  = 11;
   localparam int DCNT_W  = $clog2(DIV_W);

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_OF_VIEW = 3'd4;

   typedef struct packed {
      logic capture;
      logic write_cell;
      logic clear_run;
      logic div_angle;
      logic div_ceil;
      logic trig_load;
      logic march_init;
      logic march_run;
      logic rsp_load;
   } grc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_busy;
      logic march_done;
   } grc_sts_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] whole;
      logic [REM_W-1:0]         rem;
   } grc_axis_type;

   function automatic logic [14:0] sine_tab(input logic [5:0] i);
      logic [14:0] v;
      case (i)
         6'd0:  v = 15'd0;
         6'd1:  v = 15'd804;
         6'd2:  v = 15'd1606;
         6'd3:  v = 15'd2404;
         6'd4:  v = 15'd3196;
         6'd5:  v = 15'd3981;
         6'd6:  v = 15'd4756;
         6'd7:  v = 15'd5520;
         6'd8:  v = 15'd6270;
         6'd9:  v = 15'd7005;
         6'd10: v = 15'd7723;
         6'd11: v = 15'd8423;
         6'd12: v = 15'd9102;
         6'd13: v = 15'd9760;
         6'd14: v = 15'd10394;
         6'd15: v = 15'd11003;
         6'd16: v = 15'd11585;
         6'd17: v = 15'd12140;
         6'd18: v = 15'd12665;
         6'd19: v = 15'd13160;
         6'd20: v = 15'd13623;
         6'd21: v = 15'd14053;
         6'd22: v = 15'd14449;
         6'd23: v = 15'd14811;
         6'd24: v = 15'd15137;
         6'd25: v = 15'd15426;
         6'd26: v = 15'd15679;
         6'd27: v = 15'd15893;
         6'd28: v = 15'd16069;
         6'd29: v = 15'd16207;
         6'd30: v = 15'd16305;
         6'd31: v = 15'd16364;
         default: v = 15'd16384;
      endcase
      return v;
   endfunction

   // interpolate within a quarter turn (q in 0..16384)
   function automatic logic [14:0] quarter_value(input logic [14:0] q);
      logic [5:0]  i;
      logic [8:0]  f;
      logic [14:0] t0;
      logic [14:0] t1;
      logic [9:0]  d;
      logic [18:0] p;
      i  = q[14:9];
      f  = q[8:0];
      t0 = sine_tab(i);
      t1 = sine_tab(i + 6'd1);
      d  = 10'(t1 - t0);
      p  = 19'(d) * 19'(f);
      if (i >= 6'd32) begin
         return 15'd16384;
      end
      return t0 + 15'(p >> 9);
   endfunction

   function automatic logic signed [15:0] sine_of(input logic [15:0] p);
      logic [14:0] a;
      logic [14:0] v;
      a = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
      v = quarter_value(a);
      return p[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

   function automatic logic [SHADE_W-1:0] shade_of(input logic [STEP_W-1:0] s);
      logic [SHADE_W-1:0] sh;
      sh = '0;
      if ({s, 3'b000} <= 13'(MAX_STEPS)) begin
         sh = 4'd8;
      end else begin
         for (int n = 7; n >= 1; n--) begin
            if (sh == '0 && 13'(n) * 13'(s) < 13'(MAX_STEPS)) begin
               sh = SHADE_W'(n);
            end
         end
      end
      return sh;
   endfunction

endpackage

`default_nettype wire

>>> sv/grc_if.sv
// ----------------------------------------------------------------------------
// grc_if: channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface grc_req_if import grc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [CELL_XY_W-1:0] cell_x;
   logic [CELL_XY_W-1:0] cell_y;
   logic                 cell_wall;
   logic [POS_W-1:0]     player_x;
   logic [POS_W-1:0]     player_y;
   logic [ANGLE_W-1:0]   player_angle;
   logic [COLUMN_W-1:0]  column;
   modport source(output valid, operation, cell_x, cell_y, cell_wall, player_x,
                  player_y, player_angle, column, input ready);
   modport sink(input valid, operation, cell_x, cell_y, cell_wall, player_x,
                player_y, player_angle, column, output ready);
endinterface

interface grc_rsp_if import grc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COLUMN_W-1:0] column_echo;
   logic [ROW_W-1:0]    ceiling_row;
   logic [ROW_W-1:0]    floor_row;
   logic [SHADE_W-1:0]  shade;
   logic [STEP_W-1:0]   distance_steps;
   logic                out_of_map;
   modport source(output valid, column_echo, ceiling_row, floor_row, shade,
                  distance_steps, out_of_map, input ready);
   modport sink(input valid, column_echo, ceiling_row, floor_row, shade,
                distance_steps, out_of_map, output ready);
endinterface

interface grc_csr_if import grc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/grc_ram.sv
// ----------------------------------------------------------------------------
// grc_ram: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/grc_div.sv
// ----------------------------------------------------------------------------
// grc_div: restoring divider
// Unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_div import grc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [DIVR_W-1:0] divisor,
   output logic                   busy,
   output logic      [DIV_W-1:0]  quotient
);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] den_ff;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIVR_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIVR_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/grc_dp.sv
// ----------------------------------------------------------------------------
// grc_dp: raycaster datapath
// Registers, wall grid, angle and ceiling division, sine lookup and the
// pipelined march (advance, grid read, hit check).
// ----------------------------------------------------------------------------
`default_nettype none

module grc_dp import grc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire grc_cmd_type          cmd,
   output grc_sts_type               sts,
   input  wire logic [CELL_XY_W-1:0] req_cell_x,
   input  wire logic [CELL_XY_W-1:0] req_cell_y,
   input  wire logic                 req_cell_wall,
   input  wire logic [POS_W-1:0]     req_player_x,
   input  wire logic [POS_W-1:0]     req_player_y,
   input  wire logic [ANGLE_W-1:0]   req_player_angle,
   input  wire logic [COLUMN_W-1:0]  req_column,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output logic      [COLUMN_W-1:0]  rsp_column_echo,
   output logic      [ROW_W-1:0]     rsp_ceiling_row,
   output logic      [ROW_W-1:0]     rsp_floor_row,
   output logic      [SHADE_W-1:0]   rsp_shade,
   output logic      [STEP_W-1:0]    rsp_distance_steps,
   output logic                      rsp_out_of_map
);

   // configuration
   logic [9:0]  screen_width_ff;
   logic [8:0]  screen_height_ff;
   logic [5:0]  map_width_ff;
   logic [5:0]  map_height_ff;
   logic [10:0] field_of_view_ff;

   // captured request
   logic [CELL_XY_W-1:0] cell_x_ff, cell_y_ff;
   logic                 cell_wall_ff;
   logic [POS_W-1:0]     player_x_ff, player_y_ff;
   logic [ANGLE_W-1:0]   player_angle_ff;
   logic [COLUMN_W-1:0]  column_ff;

   logic [ADDR_W-1:0] clear_cnt_ff;

   logic signed [15:0] unit_x_ff, unit_y_ff;
   grc_axis_type       axis_x_ff, axis_y_ff, axis_x_in, axis_y_in;
   logic [STEP_W-1:0]  step_ff;
   logic               p1_valid_ff, p1_valid_in;
   logic [STEP_W-1:0]  p1_step_ff;
   logic               p1_oob_ff, p1_oob_in;
   logic [STEP_W-1:0]  steps_ff;
   logic               out_map_ff;

   // divider hookup
   logic              div_busy;
   logic [DIV_W-1:0]  div_quo;
   logic [DIV_W-1:0]  div_num;
   logic [DIVR_W-1:0] div_den;

   // grid ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_data;

   logic [ANGLE_W-1:0] ray;
   logic [15:0]        phase;
   logic [5:0]         mw, mh;
   logic [IDX_W-1:0]   idx_x, idx_y;
   logic               issue;
   logic               hit_wall;
   logic               done;

   function automatic grc_axis_type axis_step(input grc_axis_type a,
                                              input logic signed [15:0] unit);
      logic signed [REM_W:0] sum;
      grc_axis_type          r;
      sum = $signed({1'b0, a.rem}) + $signed({{3{unit[15]}}, unit, 8'h00});
      r   = a;
      if (sum >= PROBE_DEN) begin
         r.whole = a.whole + 7'sd1;
         r.rem   = REM_W'(sum - PROBE_DEN);
      end else if (sum < 0) begin
         r.whole = a.whole - 7'sd1;
         r.rem   = REM_W'(sum + PROBE_DEN);
      end else begin
         r.rem   = sum[REM_W-1:0];
      end
      return r;
   endfunction

   // outside when at or below -1 cell, or at or past the used size
   function automatic logic axis_out(input grc_axis_type a, input logic [5:0] size);
      logic below;
      logic past;
      below = (a.whole < -7'sd1) || (a.whole == -7'sd1 && a.rem == '0);
      // a probe just below zero truncates to cell 0
      past  = a.whole[CELL_W-1] ? (size == '0) : (a.whole >= $signed({1'b0, size}));
      return below || past;
   endfunction

   function automatic logic [IDX_W-1:0] axis_idx(input grc_axis_type a);
      return a.whole[CELL_W-1] ? '0 : a.whole[IDX_W-1:0];
   endfunction

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= 10'd80;
         screen_height_ff <= 9'd24;
         map_width_ff     <= 6'd20;
         map_height_ff    <= 6'd20;
         field_of_view_ff <= 11'd512;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data[9:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[8:0];
            CSR_MAP_WIDTH:     map_width_ff     <= csr_data[5:0];
            CSR_MAP_HEIGHT:    map_height_ff    <= csr_data[5:0];
            CSR_FIELD_OF_VIEW: field_of_view_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cell_x_ff       <= req_cell_x;
         cell_y_ff       <= req_cell_y;
         cell_wall_ff    <= req_cell_wall;
         player_x_ff     <= req_player_x;
         player_y_ff     <= req_player_y;
         player_angle_ff <= req_player_angle;
         column_ff       <= req_column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_run) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
      end
   end

   // -------------------------------------------------------------- division
   always_comb begin
      if (cmd.div_angle) begin
         div_num = DIV_W'(column_ff) * DIV_W'(field_of_view_ff);
         div_den = (screen_width_ff == '0) ? DIVR_W'(1) : DIVR_W'(screen_width_ff);
      end else begin
         div_num = (steps_ff > NEAR_STEPS) ?
                   DIV_W'(screen_height_ff) * DIV_W'(steps_ff - NEAR_STEPS) : '0;
         div_den = {steps_ff, 1'b0};
      end
   end

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_angle | cmd.div_ceil),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // ------------------------------------------------------------ unit vector
   assign ray   = ANGLE_W'(player_angle_ff - ANGLE_W'(field_of_view_ff >> 1)
                           + div_quo[ANGLE_W-1:0]);
   assign phase = {ray, (16 - ANGLE_W)'(0)};

   always_ff @(posedge clock) begin
      if (cmd.trig_load) begin
         unit_y_ff <= sine_of(phase);
         unit_x_ff <= sine_of(16'(phase + 16'd16384));
      end
   end

   // ----------------------------------------------------------------- march
   assign mw = (map_width_ff > 6'(GRID_SIDE)) ? 6'(GRID_SIDE) : map_width_ff;
   assign mh = (map_height_ff > 6'(GRID_SIDE)) ? 6'(GRID_SIDE) : map_height_ff;

   assign axis_x_in = axis_step(axis_x_ff, unit_x_ff);
   assign axis_y_in = axis_step(axis_y_ff, unit_y_ff);
   assign idx_x     = axis_idx(axis_x_ff);
   assign idx_y     = axis_idx(axis_y_ff);
   assign issue     = cmd.march_run && step_ff != '0 && step_ff <= MAX_STEPS;
   assign p1_valid_in = issue;
   assign p1_oob_in   = axis_out(axis_x_ff, mw) || axis_out(axis_y_ff, mh);

   assign hit_wall = rd_data;
   assign done     = p1_valid_ff && (p1_oob_ff || hit_wall || p1_step_ff == MAX_STEPS);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (cmd.march_init) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
      end
      if (cmd.march_init) begin
         axis_x_ff.whole <= CELL_W'(player_x_ff[POS_W-1:8]);
         axis_x_ff.rem   <= REM_W'(player_x_ff[7:0]) * FRAC_SCALE;
         axis_y_ff.whole <= CELL_W'(player_y_ff[POS_W-1:8]);
         axis_y_ff.rem   <= REM_W'(player_y_ff[7:0]) * FRAC_SCALE;
         step_ff         <= '0;
      end else if (cmd.march_run && step_ff <= MAX_STEPS) begin
         axis_x_ff <= axis_x_in;
         axis_y_ff <= axis_y_in;
         step_ff   <= step_ff + 1'b1;
      end
      p1_step_ff <= step_ff;
      p1_oob_ff  <= p1_oob_in;
      if (cmd.march_run && done) begin
         steps_ff   <= (p1_oob_ff || !hit_wall) ? MAX_STEPS : p1_step_ff;
         out_map_ff <= p1_oob_ff || !hit_wall;
      end
   end

   // ------------------------------------------------------------ wall grid
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clear_cnt_ff;
      wr_data = 1'b0;
      if (cmd.clear_run) begin
         wr_en = 1'b1;
      end else if (cmd.write_cell && 32'(cell_x_ff) < GRID_SIDE
                   && 32'(cell_y_ff) < GRID_SIDE) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_W'(32'(cell_y_ff) * GRID_SIDE + 32'(cell_x_ff));
         wr_data = cell_wall_ff;
      end
   end

   assign rd_en   = issue;
   assign rd_addr = ADDR_W'(32'(idx_y) * GRID_SIDE + 32'(idx_x));

   grc_ram #(
      .WIDTH (1),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------- response
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_column_echo    <= column_ff;
         rsp_ceiling_row    <= div_quo[ROW_W-1:0];
         rsp_floor_row      <= ROW_W'(screen_height_ff - div_quo[ROW_W-1:0]);
         rsp_shade          <= shade_of(steps_ff);
         rsp_distance_steps <= steps_ff;
         rsp_out_of_map     <= out_map_ff;
      end
   end

   assign sts.clear_last = (clear_cnt_ff == ADDR_W'(GRID_DEPTH - 1));
   assign sts.div_busy   = div_busy;
   assign sts.march_done = done;

endmodule

`default_nettype wire

>>> sv/grc_ctrl.sv
// ----------------------------------------------------------------------------
// grc_ctrl: raycaster controller
// Sequences grid clear, cell writes and the phases of a column cast,
// and owns the request/response handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module grc_ctrl import grc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_operation,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output grc_cmd_type      cmd,
   input  wire grc_sts_type sts
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_WRITE = 4'd2;
   localparam logic [3:0] S_ANGLE = 4'd3;
   localparam logic [3:0] S_DIVA  = 4'd4;
   localparam logic [3:0] S_TRIG  = 4'd5;
   localparam logic [3:0] S_INIT  = 4'd6;
   localparam logic [3:0] S_MARCH = 4'd7;
   localparam logic [3:0] S_CEIL  = 4'd8;
   localparam logic [3:0] S_DIVC  = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_run = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_operation == OP_CAST) ? S_ANGLE : S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.write_cell = 1'b1;
            state_in       = S_IDLE;
         end
         S_ANGLE: begin
            cmd.div_angle = 1'b1;
            state_in      = S_DIVA;
         end
         S_DIVA: begin
            if (!sts.div_busy) begin
               state_in = S_TRIG;
            end
         end
         S_TRIG: begin
            cmd.trig_load = 1'b1;
            state_in      = S_INIT;
         end
         S_INIT: begin
            cmd.march_init = 1'b1;
            state_in       = S_MARCH;
         end
         S_MARCH: begin
            cmd.march_run = 1'b1;
            if (sts.march_done) begin
               state_in = S_CEIL;
            end
         end
         S_CEIL: begin
            cmd.div_ceil = 1'b1;
            state_in     = S_DIVC;
         end
         S_DIVC: begin
            if (!sts.div_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_reset_clears : assert property (@(posedge clock)
      $past(reset) |-> state_ff == S_CLEAR && !rsp_valid_ff)
      else $error("reset did not start the grid clear");

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

   a_march_no_div : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MARCH |-> !sts.div_busy)
      else $error("divider busy during march");

   a_write_returns : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE |=> state_ff == S_IDLE)
      else $error("cell write did not return to idle");

endmodule

`default_nettype wire

>>> sv/grid_raycast_column.sv
// ----------------------------------------------------------------------------
// grid_raycast_column: column raycaster over a one-bit wall grid
// Casts one ray per screen column and returns wall rows, shade and distance.
// ----------------------------------------------------------------------------
// Usage:
//   req: one transaction per item. operation 0 writes cell (cell_x, cell_y)
//        of the 32x32 grid with cell_wall and returns nothing; operation 1
//        casts the ray of one column from the player pose.
//   rsp: one transaction per cast, carrying column_echo, ceiling_row,
//        floor_row, shade, distance_steps and out_of_map.
//   csr: register writes (0 screen_width, 1 screen_height, 2 map_width,
//        3 map_height, 4 field_of_view); always ready. Write only when idle.
// Cast:
//   A cast runs an angle division, the march pipeline at one probe per
//   cycle (at most 200 grid probes), and a ceiling division, both divisions
//   on the shared bit-serial divider.
//   One item is in work at a time.
// Reset:
//   Synchronous, active high. Registers take their defaults, then the grid
//   is cleared one cell a cycle, all 1024 cells, with req held not ready.
// Stall:
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and a later result holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_raycast_column import grc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   grc_req_if.sink  req,
   grc_rsp_if.source rsp,
   grc_csr_if.sink  csr
);

   grc_cmd_type cmd;
   grc_sts_type sts;

   assign csr.ready = 1'b1;

   grc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_operation (req.operation),
      .req_ready     (req.ready),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .cmd           (cmd),
      .sts           (sts)
   );

   grc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_cell_x         (req.cell_x),
      .req_cell_y         (req.cell_y),
      .req_cell_wall      (req.cell_wall),
      .req_player_x       (req.player_x),
      .req_player_y       (req.player_y),
      .req_player_angle   (req.player_angle),
      .req_column         (req.column),
      .csr_we             (csr.valid),
      .csr_index          (csr.index),
      .csr_data           (csr.data),
      .rsp_column_echo    (rsp.column_echo),
      .rsp_ceiling_row    (rsp.ceiling_row),
      .rsp_floor_row      (rsp.floor_row),
      .rsp_shade          (rsp.shade),
      .rsp_distance_steps (rsp.distance_steps),
      .rsp_out_of_map     (rsp.out_of_map)
   );

endmodule

`default_nettype wire
